// ----- sv/udprc_pkg.sv -----
// Package for the UDP receive check block: verdict codes, header offsets
// and the record that passes a finished segment to the verdict stage.
// Depends on nothing; every other file of the block but udprc_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package udprc_pkg;

	typedef enum logic [1:0] {
		VERDICT_OK           = 2'd0,
		VERDICT_HDR_SHORT    = 2'd1,
		VERDICT_BAD_LENGTH   = 2'd2,
		VERDICT_BAD_CHECKSUM = 2'd3
	} verdict_t;

	// Byte offsets of the UDP header fields.
	localparam logic [15:0] OFF_FROM_PORT = 16'd0;
	localparam logic [15:0] OFF_TO_PORT   = 16'd2;
	localparam logic [15:0] OFF_LENGTH    = 16'd4;
	localparam logic [15:0] OFF_CHECKSUM  = 16'd6;
	localparam logic [15:0] HEADER_BYTES  = 16'd8;

	localparam logic [1:0]  WB_ONE       = 2'd1;
	localparam logic [15:0] BYTE_MAX     = 16'hffff;
	localparam logic [15:0] SUM_GOOD     = 16'hffff;
	localparam logic [18:0] UDP_PROTO    = 19'd17;

	// Totals of one segment, taken after its last word.
	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] bytes;
		logic [15:0] seg_len;
		logic [15:0] from_port;
		logic [15:0] to_port;
		logic        csum_present;
		logic [18:0] pseudo;
		logic [31:0] from_addr;
	} seg_total_t;

endpackage

`default_nettype wire

// ----- sv/udprc_if.sv -----
// Handshake channels of the UDP receive check block: the segment word
// input and the verdict output. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface udprc_seg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_word;
	logic [1:0]  word_bytes;
	logic        last;
	logic [31:0] source_address;
	logic [31:0] target_address;

	modport source (output valid, data_word, word_bytes, last, source_address,
		target_address, input ready);
	modport sink (input valid, data_word, word_bytes, last, source_address,
		target_address, output ready);
endinterface

interface udprc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] sender_port;
	logic [15:0] receiver_port;
	logic [15:0] payload_bytes;
	logic [31:0] sender_address;

	modport source (output valid, verdict, sender_port, receiver_port,
		payload_bytes, sender_address, input ready);
	modport sink (input valid, verdict, sender_port, receiver_port,
		payload_bytes, sender_address, output ready);
endinterface

`default_nettype wire

// ----- sv/udp_receive_check.sv -----
// UDP receive check: checksum and length verification of received IPv4 UDP
// segments. The segment enters one 16-bit big-endian word per transfer on
// the segment channel, starting at the UDP header, with the IP source and
// destination addresses alongside; the sender is to set word_bytes to 1 only
// on an odd final word (the block does not enforce this). The block takes one
// word in every clock cycle, with no gaps between segments, unless a last word
// waits on a full totals register, and gives one verdict transfer on the
// result channel for each word marked last. The accumulation register sets
// the rate, taking each word's sum, byte count and header fields. Verdicts are
// accepted, header short (fewer than eight bytes), bad length (UDP length
// below eight or above the bytes received) and bad checksum (the checksum over
// the UDP length plus the pseudo-header does not fold to all ones). A zero
// checksum field skips the check. Ports and payload length are given only on
// accept and read as zero otherwise; the source address is always given. Bytes
// past the UDP length are not summed, and the byte count saturates at 65535.
// Depends on udprc_pkg, udprc_if, udprc_accum and udprc_verdict.
`timescale 1ns / 1ps
`default_nettype none

module udp_receive_check import udprc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	udprc_seg_if.sink   segment,
	udprc_res_if.source result
);

	// Segment totals travel from the accumulator to the verdict stage through
	// a one-entry register, so a new segment can start while the previous
	// verdict is still being worked out or waits on the result channel.
	logic       total_valid;
	logic       total_ready;
	seg_total_t total;

	// Word accumulation: input register, running sum and header fields.
	udprc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.segment     (segment),
		.total_valid (total_valid),
		.total_ready (total_ready),
		.total       (total)
	);

	// Length checks, pseudo-header fold and the result register.
	udprc_verdict u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.total_valid (total_valid),
		.total_ready (total_ready),
		.total       (total),
		.result      (result)
	);

endmodule

`default_nettype wire

// ----- sv/udprc_accum.sv -----
// Input register and per-word accumulation of the UDP receive check:
// running checksum, byte count and header capture, then the segment totals.
// Depends on udprc_pkg and udprc_seg_if.
`timescale 1ns / 1ps
`default_nettype none

module udprc_accum import udprc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	udprc_seg_if.sink    segment,
	output logic         total_valid,
	input  logic         total_ready,
	output seg_total_t   total
);

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        one_byte_s1;
	logic        last_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;

	logic [15:0] sum_q;
	logic [15:0] bytes_q;
	logic [15:0] seg_len_q;
	logic [15:0] from_port_q;
	logic [15:0] to_port_q;
	logic        csum_present_q;

	logic        valid_s2;
	seg_total_t  total_s2;

	logic        s2_free;
	logic        s1_go;
	logic [15:0] valid_w;
	logic [15:0] upper_w;
	logic [15:0] add_w;
	logic [15:0] remain;
	logic [16:0] sum_raw;
	logic [16:0] bytes_raw;
	seg_total_t  nx;

	assign s2_free       = !valid_s2 || total_ready;
	assign s1_go         = valid_s1 && (!last_s1 || s2_free);
	assign segment.ready = !valid_s1 || s1_go;
	assign total_valid   = valid_s2;
	assign total         = total_s2;

	always_comb begin
		upper_w = {word_s1[15:8], 8'h00};
		valid_w = one_byte_s1 ? upper_w : word_s1;

		nx.from_port    = from_port_q;
		nx.to_port      = to_port_q;
		nx.seg_len      = seg_len_q;
		nx.csum_present = csum_present_q;
		if (bytes_q == OFF_FROM_PORT) begin
			nx.from_port = valid_w;
		end else if (bytes_q == OFF_TO_PORT) begin
			nx.to_port = valid_w;
		end else if (bytes_q == OFF_LENGTH) begin
			nx.seg_len = valid_w;
		end else if (bytes_q == OFF_CHECKSUM) begin
			nx.csum_present = (valid_w != 16'h0000);
		end

		// Only bytes inside the UDP length count toward the checksum; the
		// first two header words always do.
		remain = nx.seg_len - bytes_q;
		if (bytes_q < OFF_LENGTH) begin
			add_w = valid_w;
		end else if (bytes_q < nx.seg_len) begin
			add_w = (remain == 16'd1) ? upper_w : valid_w;
		end else begin
			add_w = 16'h0000;
		end

		sum_raw = {1'b0, sum_q} + {1'b0, add_w};
		nx.sum  = sum_raw[15:0] + {15'd0, sum_raw[16]};

		bytes_raw = {1'b0, bytes_q} + (one_byte_s1 ? 17'd1 : 17'd2);
		nx.bytes  = bytes_raw[16] ? BYTE_MAX : bytes_raw[15:0];

		nx.pseudo = {3'd0, src_s1[31:16]} + {3'd0, src_s1[15:0]}
			+ {3'd0, dst_s1[31:16]} + {3'd0, dst_s1[15:0]} + UDP_PROTO;
		nx.from_addr = src_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (segment.valid && segment.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (segment.valid && segment.ready) begin
			word_s1     <= segment.data_word;
			one_byte_s1 <= (segment.word_bytes == WB_ONE);
			last_s1     <= segment.last;
			src_s1      <= segment.source_address;
			dst_s1      <= segment.target_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			bytes_q        <= '0;
			seg_len_q      <= '0;
			from_port_q    <= '0;
			to_port_q      <= '0;
			csum_present_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				sum_q          <= '0;
				bytes_q        <= '0;
				seg_len_q      <= '0;
				from_port_q    <= '0;
				to_port_q      <= '0;
				csum_present_q <= 1'b0;
			end else begin
				sum_q          <= nx.sum;
				bytes_q        <= nx.bytes;
				seg_len_q      <= nx.seg_len;
				from_port_q    <= nx.from_port;
				to_port_q      <= nx.to_port;
				csum_present_q <= nx.csum_present;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (total_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			total_s2 <= nx;
		end
	end

endmodule

`default_nettype wire

// ----- sv/udprc_verdict.sv -----
// Verdict stage of the UDP receive check: length checks, pseudo-header
// checksum fold and the registered result. Depends on udprc_pkg and udprc_res_if.
`timescale 1ns / 1ps
`default_nettype none

module udprc_verdict import udprc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         total_valid,
	output logic         total_ready,
	input  seg_total_t   total,
	udprc_res_if.source  result
);

	logic        valid_q;
	verdict_t    verdict_q;
	logic [15:0] from_port_q;
	logic [15:0] to_port_q;
	logic [15:0] payload_q;
	logic [31:0] from_addr_q;

	logic        load;
	logic [19:0] csum_raw;
	logic [16:0] csum_fold1;
	logic [15:0] csum_fold2;
	verdict_t    verdict_nx;

	assign load        = total_valid && (!valid_q || result.ready);
	assign total_ready = load;

	always_comb begin
		csum_raw   = {4'd0, total.sum} + {1'b0, total.pseudo} + {4'd0, total.seg_len};
		csum_fold1 = {1'b0, csum_raw[15:0]} + {13'd0, csum_raw[19:16]};
		csum_fold2 = csum_fold1[15:0] + {15'd0, csum_fold1[16]};

		if (total.bytes < HEADER_BYTES) begin
			verdict_nx = VERDICT_HDR_SHORT;
		end else if (total.seg_len < HEADER_BYTES || total.seg_len > total.bytes) begin
			verdict_nx = VERDICT_BAD_LENGTH;
		end else if (total.csum_present && csum_fold2 != SUM_GOOD) begin
			verdict_nx = VERDICT_BAD_CHECKSUM;
		end else begin
			verdict_nx = VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q   <= verdict_nx;
			from_addr_q <= total.from_addr;
			if (verdict_nx == VERDICT_OK) begin
				from_port_q <= total.from_port;
				to_port_q   <= total.to_port;
				payload_q   <= total.seg_len - HEADER_BYTES;
			end else begin
				from_port_q <= '0;
				to_port_q   <= '0;
				payload_q   <= '0;
			end
		end
	end

	assign result.valid          = valid_q;
	assign result.verdict        = verdict_q;
	assign result.sender_port    = from_port_q;
	assign result.receiver_port  = to_port_q;
	assign result.payload_bytes  = payload_q;
	assign result.sender_address = from_addr_q;

endmodule

`default_nettype wire

// ----- dv/tb_udp_receive_check.sv -----
// Self-checking testbench for udp_receive_check: drives UDP segments word by word,
// predicts each verdict in a scoreboard class and compares every result transfer.
// Depends on udprc_pkg, udprc_if and the udp_receive_check RTL.
`timescale 1ns / 1ps

module tb_udp_receive_check import udprc_pkg::*; ();

	// Word size codes. Only the one-byte code is special; every other code
	// moves two bytes, so the two odd spellings are exercised as well.
	localparam logic [1:0] WB_PAIR       = 2'd2;
	localparam logic [1:0] WB_PAIR_CODE0 = 2'd0;
	localparam logic [1:0] WB_PAIR_CODE3 = 2'd3;

	// No mid-segment odd byte is wanted when the split position is this.
	localparam int NO_ODD = -1;

	// Words of random traffic in each of the four pacing phases.
	localparam int unsigned PHASE_WORDS = 225;
	// The run is abandoned after this many cycles. The slowest correct run is
	// about a thousand words, slowed down in the paced phases, and this limit
	// leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT = 40000;
	// Cycles allowed after the last verdict.
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef enum int {
		CSUM_RIGHT,
		CSUM_ABSENT,
		CSUM_FLIPPED,
		CSUM_RANDOM
	} csum_mode_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic [1:0]  word_bytes;
		logic        last;
		logic [31:0] source_address;
		logic [31:0] target_address;
	} seg_word_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [15:0] sender_port;
		logic [15:0] receiver_port;
		logic [15:0] payload_bytes;
		logic [31:0] sender_address;
	} verdict_rec_t;

	// Scoreboard. It keeps its own copy of the block's accumulation state,
	// turns every accepted word into that state's next value, and on a last
	// word queues the verdict the block has to give.
	class verdict_board;
		logic [16:0] sum_acc;
		logic [15:0] byte_count;
		logic [15:0] udp_length;
		logic [15:0] port_a;
		logic [15:0] port_b;
		bit          csum_nonzero;

		verdict_rec_t pending_verdicts[$];
		int unsigned  fault_count;
		int unsigned  verdict_tally[4];

		function new();
			clear_segment();
			fault_count = 0;
			foreach (verdict_tally[i]) verdict_tally[i] = 0;
		endfunction

		function void clear_segment();
			sum_acc = '0;
			byte_count = '0;
			udp_length = '0;
			port_a = '0;
			port_b = '0;
			csum_nonzero = 1'b0;
		endfunction

		function int unsigned fold16(int unsigned s);
			s = (s & 32'hffff) + (s >> 16);
			s = (s & 32'hffff) + (s >> 16);
			return s;
		endfunction

		function void note_word(seg_word_t w);
			int unsigned off, nb, half, room, addend, total;
			verdict_rec_t v;
			off = byte_count;
			nb = (w.word_bytes == WB_ONE) ? 1 : 2;
			half = (nb == 1) ? {w.data_word[15:8], 8'h00} : w.data_word;

			// Header fields are caught only by a word that starts on them.
			case (16'(off))
				OFF_FROM_PORT: port_a = 16'(half);
				OFF_TO_PORT:   port_b = 16'(half);
				OFF_LENGTH:    udp_length = 16'(half);
				OFF_CHECKSUM:  csum_nonzero = (half != 0);
				default: ;
			endcase

			if (off < OFF_LENGTH)
				room = nb;
			else if (off < udp_length)
				room = (udp_length - off < nb) ? udp_length - off : nb;
			else
				room = 0;
			addend = (room == 0) ? 0 : (room == 1) ? {w.data_word[15:8], 8'h00} : half;
			sum_acc = 17'(fold16(sum_acc + addend));
			byte_count = (off + nb > BYTE_MAX) ? BYTE_MAX : 16'(off + nb);

			if (!w.last)
				return;

			v = '0;
			v.sender_address = w.source_address;
			if (byte_count < HEADER_BYTES) begin
				v.verdict = VERDICT_HDR_SHORT;
			end else if (udp_length < HEADER_BYTES || udp_length > byte_count) begin
				v.verdict = VERDICT_BAD_LENGTH;
			end else begin
				total = sum_acc;
				total += w.source_address[31:16];
				total += w.source_address[15:0];
				total += w.target_address[31:16];
				total += w.target_address[15:0];
				total += UDP_PROTO;
				total += udp_length;
				total = fold16(total);
				if (csum_nonzero && total != SUM_GOOD) begin
					v.verdict = VERDICT_BAD_CHECKSUM;
				end else begin
					v.verdict = VERDICT_OK;
					v.sender_port = port_a;
					v.receiver_port = port_b;
					v.payload_bytes = udp_length - HEADER_BYTES;
				end
			end
			pending_verdicts.push_back(v);
			clear_segment();
		endfunction

		function void check_verdict(verdict_rec_t got);
			verdict_rec_t want;
			if (pending_verdicts.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("[%0t] verdict transfer with none pending: verdict %0d port %h/%h",
						$realtime, got.verdict, got.sender_port, got.receiver_port);
				return;
			end
			want = pending_verdicts.pop_front();
			verdict_tally[want.verdict]++;
			if (got.verdict !== want.verdict || got.sender_port !== want.sender_port ||
				got.receiver_port !== want.receiver_port ||
				got.payload_bytes !== want.payload_bytes ||
				got.sender_address !== want.sender_address) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("[%0t] verdict mismatch", $realtime);
					$display("  expected: verdict %0d sport %h dport %h payload %0d addr %h",
						want.verdict, want.sender_port, want.receiver_port,
						want.payload_bytes, want.sender_address);
					$display("  actual:   verdict %0d sport %h dport %h payload %0d addr %h",
						got.verdict, got.sender_port, got.receiver_port,
						got.payload_bytes, got.sender_address);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	udprc_seg_if seg_ch ();
	udprc_res_if res_ch ();

	udp_receive_check dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.segment (seg_ch),
		.result  (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	verdict_board board;

	// Pacing knobs, changed between phases by the stimulus process.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	int unsigned cycle_count = 0;
	int unsigned accepted_words = 0;
	int unsigned sent_segments = 0;

	// Bytes of the segment under construction, then its split into words.
	logic [7:0] seg_bytes[$];
	seg_word_t  seg_words[$];

	// Watchdog. A hung handshake on either side ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d verdicts pending.",
				cycle_count, board.pending_verdicts.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side. Every accepted transfer goes to the scoreboard, and ready
	// is redrawn each cycle according to the current stall rate.
	always @(posedge clk) begin : result_sink
		verdict_rec_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.verdict = res_ch.verdict;
			got.sender_port = res_ch.sender_port;
			got.receiver_port = res_ch.receiver_port;
			got.payload_bytes = res_ch.payload_bytes;
			got.sender_address = res_ch.sender_address;
			board.check_verdict(got);
		end
		res_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// Offers one word and holds it until the block takes it. Idle cycles
	// are inserted in front of the word at the current idle rate; valid is
	// dropped for them and raised again only with the new word.
	task automatic send_word(input seg_word_t w);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			seg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.data_word <= w.data_word;
		seg_ch.word_bytes <= w.word_bytes;
		seg_ch.last <= w.last;
		seg_ch.source_address <= w.source_address;
		seg_ch.target_address <= w.target_address;
		@(posedge clk);
		while (!seg_ch.ready)
			@(posedge clk);
		board.note_word(w);
		accepted_words++;
	endtask

	task automatic send_segment();
		foreach (seg_words[i])
			send_word(seg_words[i]);
		sent_segments++;
	endtask

	// The checksum the sender would place in the header: ones' complement
	// sum over the first UDP-length bytes, an odd tail padded with zero, plus
	// the pseudo-header. A result of zero is sent as all ones, since zero
	// means no checksum at all.
	function automatic logic [15:0] checksum_for(int unsigned len_field,
		logic [31:0] src, logic [31:0] dst);
		int unsigned acc, limit, i;
		logic [15:0] pair;
		limit = (len_field < seg_bytes.size()) ? len_field : seg_bytes.size();
		acc = src[31:16];
		acc += src[15:0];
		acc += dst[31:16];
		acc += dst[15:0];
		acc += UDP_PROTO;
		acc += len_field;
		for (i = 0; i < limit; i += 2) begin
			pair = {seg_bytes[i], (i + 1 < limit) ? seg_bytes[i + 1] : 8'h00};
			acc += pair;
			acc = (acc & 32'hffff) + (acc >> 16);
		end
		acc = (acc & 32'hffff) + (acc >> 16);
		acc = (acc & 32'hffff) + (acc >> 16);
		return (acc[15:0] == 16'hffff) ? 16'hffff : ~acc[15:0];
	endfunction

	// Builds the bytes of a UDP segment: header, random payload and a few
	// trailing bytes past the UDP length if asked. The length field is the
	// true one shifted by length_skew, which makes the bad length cases.
	task automatic compose_udp(input int payload_len, input int trailing,
		input int length_skew, input csum_mode_t mode, input logic [15:0] sport,
		input logic [15:0] dport, input logic [31:0] src, input logic [31:0] dst);
		logic [15:0] len_field;
		logic [15:0] csum;
		len_field = 16'(8 + payload_len + length_skew);
		seg_bytes.delete();
		seg_bytes.push_back(sport[15:8]);
		seg_bytes.push_back(sport[7:0]);
		seg_bytes.push_back(dport[15:8]);
		seg_bytes.push_back(dport[7:0]);
		seg_bytes.push_back(len_field[15:8]);
		seg_bytes.push_back(len_field[7:0]);
		seg_bytes.push_back(8'h00);
		seg_bytes.push_back(8'h00);
		repeat (payload_len + trailing)
			seg_bytes.push_back(8'($urandom));
		csum = checksum_for(len_field, src, dst);
		case (mode)
			CSUM_ABSENT:  csum = 16'h0000;
			CSUM_FLIPPED: csum = csum ^ 16'($urandom_range(1, 65535));
			CSUM_RANDOM:  csum = 16'($urandom);
			default: ;
		endcase
		seg_bytes[6] = csum[15:8];
		seg_bytes[7] = csum[7:0];
	endtask

	// Splits seg_bytes into words. The final odd byte, and a byte at
	// odd_at if that position is reached, go out as one-byte words. With
	// scramble set the addresses wander on all but the last word, which is
	// the only one the pseudo-header uses.
	task automatic pack_words(input int odd_at, input logic [31:0] src,
		input logic [31:0] dst, input bit scramble);
		seg_word_t w;
		int p;
		int unsigned code_pick;
		seg_words.delete();
		p = 0;
		while (p < seg_bytes.size()) begin
			w.source_address = scramble ? $urandom : src;
			w.target_address = scramble ? $urandom : dst;
			if (p == odd_at || p == seg_bytes.size() - 1) begin
				// The low byte of a one-byte word is junk the block must ignore.
				w.data_word = {seg_bytes[p], 8'($urandom)};
				w.word_bytes = WB_ONE;
				p += 1;
			end else begin
				w.data_word = {seg_bytes[p], seg_bytes[p + 1]};
				code_pick = $urandom_range(9);
				w.word_bytes = (code_pick == 0) ? WB_PAIR_CODE0 :
					(code_pick == 1) ? WB_PAIR_CODE3 : WB_PAIR;
				p += 2;
			end
			w.last = (p >= seg_bytes.size());
			if (w.last) begin
				w.source_address = src;
				w.target_address = dst;
			end
			seg_words.push_back(w);
		end
	endtask

	// Words of arbitrary content and size code, for segments that do not
	// look like UDP at all.
	task automatic noise_segment(input int unsigned count);
		seg_word_t w;
		int unsigned k;
		seg_words.delete();
		for (k = 0; k < count; k++) begin
			w.data_word = 16'($urandom);
			w.word_bytes = 2'($urandom_range(3));
			w.last = (k == count - 1);
			w.source_address = $urandom;
			w.target_address = $urandom;
			seg_words.push_back(w);
		end
	endtask

	function automatic csum_mode_t pick_csum();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return CSUM_RIGHT;
		else if (r < 75)
			return CSUM_ABSENT;
		else if (r < 90)
			return CSUM_FLIPPED;
		return CSUM_RANDOM;
	endfunction

	// One random segment. Most are well formed with random content so the
	// checksum path is reached; the rest have bad lengths, a stray odd byte
	// in the middle, or are plain noise and runts.
	task automatic random_segment();
		int unsigned pick, plen, tail;
		int skew;
		logic [31:0] src, dst;
		pick = $urandom_range(99);
		src = $urandom;
		dst = $urandom;
		plen = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(40);
		tail = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
		if (pick < 60) begin
			compose_udp(plen, tail, 0, pick_csum(), 16'($urandom), 16'($urandom), src, dst);
			pack_words(NO_ODD, src, dst, $urandom_range(9) == 0);
		end else if (pick < 70) begin
			case ($urandom_range(2))
				0: skew = -int'(plen) - int'($urandom_range(1, 8));
				1: skew = int'(tail) + int'($urandom_range(1, 6));
				default: skew = int'($urandom_range(65535)) - 8 - int'(plen);
			endcase
			compose_udp(plen, tail, skew, pick_csum(), 16'($urandom), 16'($urandom), src, dst);
			pack_words(NO_ODD, src, dst, 1'b0);
		end else if (pick < 80) begin
			// A one-byte word inside the segment shifts every later offset;
			// at the very start it also makes the length word go missing.
			compose_udp(plen, tail, 0, pick_csum(), 16'($urandom), 16'($urandom), src, dst);
			pack_words(2 * $urandom_range(0, (seg_bytes.size() - 2) / 2), src, dst, 1'b0);
		end else if (pick < 90) begin
			noise_segment($urandom_range(1, 12));
		end else begin
			noise_segment($urandom_range(1, 3));
		end
		send_segment();
	endtask

	int unsigned idle_plan[4]  = '{0, 65, 0, 6};
	int unsigned stall_plan[4] = '{0, 0, 65, 6};

	initial begin : stimulus
		seg_word_t w;
		int unsigned phase, goal;
		board = new();

		seg_ch.valid = 1'b0;
		seg_ch.data_word = '0;
		seg_ch.word_bytes = WB_PAIR;
		seg_ch.last = 1'b0;
		seg_ch.source_address = '0;
		seg_ch.target_address = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases, all with both sides at full rate.
		// A lone one-byte word: far too short for a header.
		w.data_word = 16'hffff;
		w.word_bytes = WB_ONE;
		w.last = 1'b1;
		w.source_address = 32'hffffffff;
		w.target_address = 32'hffffffff;
		seg_words.delete();
		seg_words.push_back(w);
		send_segment();

		// Bare header with a good checksum, extreme ports and addresses.
		compose_udp(0, 0, 0, CSUM_RIGHT, 16'hffff, 16'h0000, 32'hffffffff, 32'h0);
		pack_words(NO_ODD, 32'hffffffff, 32'h0, 1'b0);
		send_segment();

		// Length field one below the header size.
		compose_udp(0, 0, -1, CSUM_RIGHT, 16'h0000, 16'hffff, 32'h0, 32'hffffffff);
		pack_words(NO_ODD, 32'h0, 32'hffffffff, 1'b0);
		send_segment();

		// Odd length: the final word carries a single byte.
		compose_udp(1, 0, 0, CSUM_RIGHT, 16'h1234, 16'h0035, 32'h0a000001, 32'hc0a80101);
		pack_words(NO_ODD, 32'h0a000001, 32'hc0a80101, 1'b0);
		send_segment();

		// Corrupted checksum.
		compose_udp(0, 0, 0, CSUM_FLIPPED, 16'h8000, 16'h0001, 32'h7f000001, 32'h7f000001);
		pack_words(NO_ODD, 32'h7f000001, 32'h7f000001, 1'b0);
		send_segment();

		// No checksum, with two bytes past the UDP length.
		compose_udp(0, 2, 0, CSUM_ABSENT, 16'h0001, 16'h8000, $urandom, $urandom);
		pack_words(NO_ODD, seg_words.size() ? 32'h01020304 : 32'h0, 32'h05060708, 1'b0);
		send_segment();

		// Length field claims more bytes than arrive.
		compose_udp(0, 0, 4, CSUM_RIGHT, 16'h00ff, 16'hff00, 32'h11111111, 32'h22222222);
		pack_words(NO_ODD, 32'h11111111, 32'h22222222, 1'b0);
		send_segment();

		// Odd UDP length with three bytes behind it: the word at the length
		// boundary keeps only its upper byte and everything after it is
		// left out of the sum.
		compose_udp(5, 3, 0, CSUM_RIGHT, 16'($urandom), 16'($urandom),
			32'hc6336401, 32'hcb007101);
		pack_words(NO_ODD, 32'hc6336401, 32'hcb007101, 1'b0);
		send_segment();

		// Random traffic in four pacing phases: full rate, sparse sender,
		// stalling receiver, then light gaps on both sides.
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = idle_plan[phase];
			stall_pct = stall_plan[phase];
			goal = accepted_words + PHASE_WORDS;
			while (accepted_words < goal)
				random_segment();
		end
		seg_ch.valid <= 1'b0;

		// Drain. A hung result channel is left to the watchdog.
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words in %0d segments across full-rate, sender-idle,",
			accepted_words, sent_segments);
		$display("receiver-stall and mixed phases; verdicts %0d ok, %0d short, %0d length, %0d csum.",
			board.verdict_tally[VERDICT_OK], board.verdict_tally[VERDICT_HDR_SHORT],
			board.verdict_tally[VERDICT_BAD_LENGTH], board.verdict_tally[VERDICT_BAD_CHECKSUM]);
		if (board.fault_count == 0 && board.pending_verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d verdicts never arrived.",
				board.fault_count, board.pending_verdicts.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/udprc_pkg.sv
sv/udprc_if.sv
sv/udprc_accum.sv
sv/udprc_verdict.sv
sv/udp_receive_check.sv
dv/tb_udp_receive_check.sv
